/* design/fbf_pkg.sv */
`timescale 1ns / 1ps
package fbf_pkg;

    // Field widths fixed by the item layout
    localparam int unsigned ADDR_W = 10;
    localparam int unsigned SIZE_W = 11;
    localparam int unsigned TAG_W  = 16;
    localparam int unsigned TYPE_W = 2;
    localparam int unsigned STAT_W = 3;

    // Heap size applied at reset
    localparam int unsigned RESET_HEAP = 1024;

    // Request type codes
    localparam logic [TYPE_W-1:0] REQ_FIRST = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_BEST  = 2'd1;
    localparam int unsigned       REQ_FREE_BIT = 1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_NO_FIT = 3'd1,
        ST_NO_TAG = 3'd2,
        ST_ZERO   = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_FS_RD,
        S_FS_CHK,
        S_CARVE,
        S_FDROP_RD,
        S_FDROP_WR,
        S_APOS_RD,
        S_APOS_CHK,
        S_AINS_RD,
        S_AINS_WR,
        S_AINS_PUT,
        S_TAG_RD,
        S_TAG_CHK,
        S_ADEL_RD,
        S_ADEL_WR,
        S_FPOS_RD,
        S_FPOS_CHK,
        S_MERGE,
        S_FINS_RD,
        S_FINS_WR,
        S_FINS_PUT,
        S_DONE
    } t_state;

    // Free segment table entry
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } t_fseg;

    // Allocation table entry
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } t_aseg;

endpackage

/* design/fbf_ram.sv */
`timescale 1ns / 1ps
module fbf_ram #(
    parameter int unsigned WIDTH = 21,
    parameter int unsigned DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/first_best_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// A rejected allocate shows its result strobe in the cycle after accept. Other requests
// walk the tables; each table entry visited takes a registered read of the free or
// allocation table (one write port, one registered read port), then a compare/write.
// Only one item is handled at a time; busy stays high from accept
// through the result strobe. Reset (synchronous, active low) and a heap_size write both
// pass through S_INIT to rebuild the heap as a single free segment. Result shown one cycle; no stall.
module first_best_fit_heap_allocator #(
    parameter int unsigned HEAP_WORDS = 1024,
    parameter int unsigned MAX_ALLOCS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fbf_pkg::TYPE_W-1:0]   i_req_type,
    input  logic [fbf_pkg::TAG_W-1:0]    i_tag,
    input  logic [fbf_pkg::SIZE_W-1:0]   i_req_size,
    output logic                         o_valid,
    output logic [fbf_pkg::STAT_W-1:0]   o_status,
    output logic [fbf_pkg::ADDR_W-1:0]   o_start_addr,
    output logic [fbf_pkg::SIZE_W-1:0]   o_free_total,
    output logic [fbf_pkg::SIZE_W-1:0]   o_alloc_total,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fbf_pkg::SIZE_W-1:0]   i_cfg_data
);
    import fbf_pkg::*;

    localparam int unsigned FD  = MAX_ALLOCS + 1;
    localparam int unsigned FAW = $clog2(FD);
    localparam int unsigned AAW = $clog2(MAX_ALLOCS);
    localparam int unsigned IW  = $clog2(FD + 1);
    localparam int unsigned ACW = $clog2(MAX_ALLOCS + 1);
    localparam logic [SIZE_W-1:0] RST_HEAP =
        SIZE_W'((HEAP_WORDS < RESET_HEAP) ? HEAP_WORDS : RESET_HEAP);

    t_state            r_state, n_state;
    t_status           r_status, n_status;
    logic [SIZE_W-1:0] r_heap, n_heap;
    logic [IW-1:0]     r_fcnt, n_fcnt;
    logic [ACW-1:0]    r_acnt, n_acnt;
    logic [SIZE_W-1:0] r_free_w, n_free_w;
    logic [SIZE_W-1:0] r_used_w, n_used_w;
    logic [IW-1:0]     r_i, n_i;
    logic [IW-1:0]     r_j, n_j;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_found, n_found;
    logic              r_best, n_best;
    logic              r_is_free, n_is_free;
    logic [ADDR_W-1:0] r_bstart, n_bstart;
    logic [SIZE_W-1:0] r_bsize, n_bsize;
    logic [SIZE_W-1:0] r_req, n_req;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [SIZE_W-1:0] r_n, n_n;
    logic [ADDR_W-1:0] r_prv_start, n_prv_start;
    logic [SIZE_W-1:0] r_prv_size, n_prv_size;
    logic [SIZE_W-1:0] r_nxt_size, n_nxt_size;
    logic              r_nxt_ok, n_nxt_ok;

    // Table ports
    logic              fs_we, as_we;
    logic [FAW-1:0]    fs_waddr, fs_raddr;
    logic [AAW-1:0]    as_waddr, as_raddr;
    t_fseg             fs_wdata, fs_q;
    t_aseg             as_wdata, as_q;

    fbf_ram #(.WIDTH($bits(t_fseg)), .DEPTH(FD)) u_free_tbl (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_raddr (fs_raddr),
        .o_rdata (fs_q)
    );

    fbf_ram #(.WIDTH($bits(t_aseg)), .DEPTH(MAX_ALLOCS)) u_alloc_tbl (
        .i_clk   (i_clk),
        .i_we    (as_we),
        .i_waddr (as_waddr),
        .i_wdata (as_wdata),
        .i_raddr (as_raddr),
        .o_rdata (as_q)
    );

    // Shared loop conditions
    logic [IW-1:0]     acnt_x, i_inc;
    logic              cfg_take, acc;
    logic              free_end, alloc_end, fdrop_more, adel_more;
    logic [SIZE_W-1:0] carve_rem, sum_end;
    logic              prv_adj;
    logic [SIZE_W-1:0] clamp_cfg;

    always_comb begin
        acnt_x     = IW'(r_acnt);
        i_inc      = r_i + 1'b1;
        cfg_take   = i_cfg_valid && o_cfg_ready;
        acc        = start && !busy && !cfg_take;
        free_end   = r_i >= r_fcnt;
        alloc_end  = r_i >= acnt_x;
        fdrop_more = i_inc < r_fcnt;
        adel_more  = i_inc < acnt_x;
        carve_rem  = r_bsize - r_req;
        sum_end    = SIZE_W'(r_prv_start) + r_prv_size;
        prv_adj    = (r_i != '0) && (sum_end == SIZE_W'(r_addr));
        if (i_cfg_data == '0) begin
            clamp_cfg = SIZE_W'(1);
        end else if (32'(i_cfg_data) > HEAP_WORDS) begin
            clamp_cfg = SIZE_W'(HEAP_WORDS);
        end else begin
            clamp_cfg = i_cfg_data;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (cfg_take) begin
                    n_state = S_INIT;
                end else if (acc) begin
                    if (i_req_type[REQ_FREE_BIT]) begin
                        n_state = S_TAG_RD;
                    end else if (i_req_size == '0 || r_acnt >= ACW'(MAX_ALLOCS)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FS_RD;
                    end
                end
            end
            S_FS_RD:    n_state = free_end ? (r_found ? S_CARVE : S_DONE) : S_FS_CHK;
            S_FS_CHK:   n_state = (!r_best && fs_q.size >= r_req) ? S_CARVE : S_FS_RD;
            S_CARVE:    n_state = (carve_rem != '0) ? S_APOS_RD : S_FDROP_RD;
            S_FDROP_RD: begin
                if (fdrop_more) begin
                    n_state = S_FDROP_WR;
                end else begin
                    n_state = r_is_free ? S_DONE : S_APOS_RD;
                end
            end
            S_FDROP_WR: n_state = S_FDROP_RD;
            S_APOS_RD:  n_state = alloc_end ? S_AINS_RD : S_APOS_CHK;
            S_APOS_CHK: n_state = (as_q.start < r_addr) ? S_APOS_RD : S_AINS_RD;
            S_AINS_RD:  n_state = (r_j > r_i) ? S_AINS_WR : S_AINS_PUT;
            S_AINS_WR:  n_state = S_AINS_RD;
            S_AINS_PUT: n_state = S_DONE;
            S_TAG_RD:   n_state = alloc_end ? S_DONE : S_TAG_CHK;
            S_TAG_CHK:  n_state = (as_q.tag == r_tag) ? S_ADEL_RD : S_TAG_RD;
            S_ADEL_RD:  n_state = adel_more ? S_ADEL_WR : S_FPOS_RD;
            S_ADEL_WR:  n_state = S_ADEL_RD;
            S_FPOS_RD:  n_state = free_end ? S_MERGE : S_FPOS_CHK;
            S_FPOS_CHK: n_state = (fs_q.start < r_addr) ? S_FPOS_RD : S_MERGE;
            S_MERGE: begin
                if (prv_adj && r_nxt_ok) begin
                    n_state = S_FDROP_RD;
                end else if (prv_adj || r_nxt_ok) begin
                    n_state = S_DONE;
                end else if (r_fcnt < IW'(FD)) begin
                    n_state = S_FINS_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FINS_RD:  n_state = (r_j > r_i) ? S_FINS_WR : S_FINS_PUT;
            S_FINS_WR:  n_state = S_FINS_RD;
            S_FINS_PUT: n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and table control
    always_comb begin
        n_status    = r_status;
        n_heap      = r_heap;
        n_fcnt      = r_fcnt;
        n_acnt      = r_acnt;
        n_free_w    = r_free_w;
        n_used_w    = r_used_w;
        n_i         = r_i;
        n_j         = r_j;
        n_idx       = r_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_is_free   = r_is_free;
        n_bstart    = r_bstart;
        n_bsize     = r_bsize;
        n_req       = r_req;
        n_tag       = r_tag;
        n_addr      = r_addr;
        n_n         = r_n;
        n_prv_start = r_prv_start;
        n_prv_size  = r_prv_size;
        n_nxt_size  = r_nxt_size;
        n_nxt_ok    = r_nxt_ok;
        fs_we       = 1'b0;
        fs_waddr    = r_i[FAW-1:0];
        fs_wdata    = fs_q;
        fs_raddr    = r_i[FAW-1:0];
        as_we       = 1'b0;
        as_waddr    = r_i[AAW-1:0];
        as_wdata    = as_q;
        as_raddr    = r_i[AAW-1:0];
        case (r_state)
            // Rebuild heap as one free segment
            S_INIT: begin
                fs_we          = 1'b1;
                fs_waddr       = '0;
                fs_wdata.start = '0;
                fs_wdata.size  = r_heap;
                n_fcnt         = IW'(1);
                n_acnt         = '0;
                n_free_w       = r_heap;
                n_used_w       = '0;
            end
            S_IDLE: begin
                if (cfg_take) begin
                    n_heap = clamp_cfg;
                end else if (acc) begin
                    n_req     = i_req_size;
                    n_tag     = i_tag;
                    n_best    = (i_req_type == REQ_BEST);
                    n_is_free = i_req_type[REQ_FREE_BIT];
                    n_addr    = '0;
                    n_i       = '0;
                    n_found   = 1'b0;
                    n_status  = ST_OK;
                    if (i_req_type[REQ_FREE_BIT]) begin
                        n_status = ST_OK;
                    end else if (i_req_size == '0) begin
                        n_status = ST_ZERO;
                    end else if (r_acnt >= ACW'(MAX_ALLOCS)) begin
                        n_status = ST_FULL;
                    end
                end
            end
            // Fit search over the free table
            S_FS_RD: begin
                if (free_end && !r_found) begin
                    n_status = ST_NO_FIT;
                end
            end
            S_FS_CHK: begin
                n_i = i_inc;
                if (fs_q.size >= r_req && (!r_best || !r_found || fs_q.size < r_bsize)) begin
                    n_found  = 1'b1;
                    n_idx    = r_i;
                    n_bstart = fs_q.start;
                    n_bsize  = fs_q.size;
                end
            end
            // Carve the low end of the chosen segment
            S_CARVE: begin
                n_addr   = r_bstart;
                n_free_w = r_free_w - r_req;
                n_used_w = r_used_w + r_req;
                if (carve_rem != '0) begin
                    fs_we          = 1'b1;
                    fs_waddr       = r_idx[FAW-1:0];
                    fs_wdata.start = ADDR_W'(SIZE_W'(r_bstart) + r_req);
                    fs_wdata.size  = carve_rem;
                    n_i            = '0;
                end else begin
                    n_i = r_idx;
                end
            end
            // Drop one free entry by shifting the tail down
            S_FDROP_RD: begin
                fs_raddr = i_inc[FAW-1:0];
                if (!fdrop_more) begin
                    n_fcnt = r_fcnt - 1'b1;
                    n_i    = '0;
                end
            end
            S_FDROP_WR: begin
                fs_we = 1'b1;
                n_i   = i_inc;
            end
            // Sorted insert into the allocation table
            S_APOS_RD: begin
                if (alloc_end) begin
                    n_j = acnt_x;
                end
            end
            S_APOS_CHK: begin
                if (as_q.start < r_addr) begin
                    n_i = i_inc;
                end else begin
                    n_j = acnt_x;
                end
            end
            S_AINS_RD: begin
                as_raddr = AAW'(r_j - 1'b1);
            end
            S_AINS_WR: begin
                as_we    = 1'b1;
                as_waddr = r_j[AAW-1:0];
                n_j      = r_j - 1'b1;
            end
            S_AINS_PUT: begin
                as_we          = 1'b1;
                as_wdata.tag   = r_tag;
                as_wdata.start = r_addr;
                as_wdata.size  = r_req;
                n_acnt         = r_acnt + 1'b1;
            end
            // Tag search
            S_TAG_RD: begin
                if (alloc_end) begin
                    n_status = ST_NO_TAG;
                end
            end
            S_TAG_CHK: begin
                if (as_q.tag == r_tag) begin
                    n_addr   = as_q.start;
                    n_n      = as_q.size;
                    n_free_w = r_free_w + as_q.size;
                    n_used_w = r_used_w - as_q.size;
                end else begin
                    n_i = i_inc;
                end
            end
            // Remove the released allocation
            S_ADEL_RD: begin
                as_raddr = i_inc[AAW-1:0];
                if (!adel_more) begin
                    n_acnt = r_acnt - 1'b1;
                    n_i    = '0;
                end
            end
            S_ADEL_WR: begin
                as_we = 1'b1;
                n_i   = i_inc;
            end
            // Locate neighbors in the free table
            S_FPOS_RD: begin
                if (free_end) begin
                    n_nxt_ok = 1'b0;
                end
            end
            S_FPOS_CHK: begin
                if (fs_q.start < r_addr) begin
                    n_prv_start = fs_q.start;
                    n_prv_size  = fs_q.size;
                    n_i         = i_inc;
                end else begin
                    n_nxt_size = fs_q.size;
                    n_nxt_ok   = (SIZE_W'(r_addr) + r_n) == SIZE_W'(fs_q.start);
                end
            end
            // Coalesce with free neighbors
            S_MERGE: begin
                if (prv_adj) begin
                    fs_we          = 1'b1;
                    fs_waddr       = FAW'(r_i - 1'b1);
                    fs_wdata.start = r_prv_start;
                    fs_wdata.size  = r_prv_size + r_n + (r_nxt_ok ? r_nxt_size : '0);
                end else if (r_nxt_ok) begin
                    fs_we          = 1'b1;
                    fs_wdata.start = r_addr;
                    fs_wdata.size  = r_nxt_size + r_n;
                end else begin
                    n_j = r_fcnt;
                end
            end
            S_FINS_RD: begin
                fs_raddr = FAW'(r_j - 1'b1);
            end
            S_FINS_WR: begin
                fs_we    = 1'b1;
                fs_waddr = r_j[FAW-1:0];
                n_j      = r_j - 1'b1;
            end
            S_FINS_PUT: begin
                fs_we          = 1'b1;
                fs_wdata.start = r_addr;
                fs_wdata.size  = r_n;
                n_fcnt         = r_fcnt + 1'b1;
            end
            S_DONE: begin
                if (r_status != ST_OK) begin
                    n_addr = '0;
                end
            end
            default: begin
                n_i = r_i;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_heap   <= RST_HEAP;
            r_fcnt   <= '0;
            r_acnt   <= '0;
            r_free_w <= '0;
            r_used_w <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_heap   <= n_heap;
            r_fcnt   <= n_fcnt;
            r_acnt   <= n_acnt;
            r_free_w <= n_free_w;
            r_used_w <= n_used_w;
            r_status <= n_status;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_best      <= n_best;
        r_is_free   <= n_is_free;
        r_bstart    <= n_bstart;
        r_bsize     <= n_bsize;
        r_req       <= n_req;
        r_tag       <= n_tag;
        r_addr      <= n_addr;
        r_n         <= n_n;
        r_prv_start <= n_prv_start;
        r_prv_size  <= n_prv_size;
        r_nxt_size  <= n_nxt_size;
        r_nxt_ok    <= n_nxt_ok;
    end

    // Ports
    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_status      = r_status;
    assign o_start_addr  = (r_status == ST_OK) ? r_addr : '0;
    assign o_free_total  = r_free_w;
    assign o_alloc_total = r_used_w;

    // Checks
    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while not busy");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_valid) |=> busy)
        else $error("accepted item did not raise busy");
    a_words_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_free_total + o_alloc_total) == r_heap)
        else $error("free plus allocated words differ from heap size");
    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_start_addr == '0)
        else $error("failed request reports nonzero address");

endmodule
